### design/eds_pkg.sv
// Package for the event deadline scheduler: constants, codes and item types.
package eds_pkg;

  localparam int NUM_TOKENS = 5;
  localparam logic signed [31:0] NEVER_TIME = 32'sd2147483647;

  localparam int TIME_W = 32;
  localparam int TOK_W  = 3;
  localparam int MASK_W = 8;
  localparam int IDX_W  = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;

  localparam logic [TOK_W:0] TOK_LIMIT = (TOK_W + 1)'(NUM_TOKENS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TOKENS - 1);

  typedef logic signed [TIME_W-1:0] time_t;

  // Request codes
  localparam logic [2:0] REQ_ADVANCE  = 3'd0;
  localparam logic [2:0] REQ_RESYNC   = 3'd1;
  localparam logic [2:0] REQ_SCHEDULE = 3'd2;
  localparam logic [2:0] REQ_CHECK    = 3'd3;
  localparam logic [2:0] REQ_REBASE   = 3'd4;

  // Sub-step of a multi-step request
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_TAIL   = 2'd2;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [TOK_W-1:0] token;
    time_t            amount;
  } in_item_t;

  typedef struct packed {
    time_t             elapsed;
    logic              negative_sync;
    logic [MASK_W-1:0] due_mask;
    time_t             earliest_deadline;
    time_t             current_time;
    logic              bad_token;
  } out_item_t;

endpackage

### design/event_deadline_scheduler_unit.sv
// Event deadline scheduler: timestamp, per-token sync and deadline times, minimum tracker.
// Order of work in S_RUN: check scans all NUM_TOKENS tokens; schedule writes the new deadline,
//   then scans for the minimum; rebase shifts each sync time and deadline in turn, then the earliest.
// One item at a time: in_ready is high only while idle; S_DONE waits for the output register.
// All arithmetic goes through the single shared 32-bit add/subtract unit and compare unit.
// Synchronous active-low reset clears control, sets the timestamp and sync times to zero and
//   every deadline and the earliest deadline to the never value; no clearing pass is needed.
module event_deadline_scheduler_unit
  import eds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Latched request
  logic [2:0]       req_r, req_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;
  time_t            amt_r, amt_nxt;

  // Sequencer position
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       ph_r, ph_nxt;

  // Architectural state
  time_t now_r, now_nxt;
  time_t earliest_r, earliest_nxt;
  time_t last_sync_r [NUM_TOKENS];
  time_t last_sync_nxt [NUM_TOKENS];
  time_t deadline_r [NUM_TOKENS];
  time_t deadline_nxt [NUM_TOKENS];

  // Result being built
  time_t             elapsed_r, elapsed_nxt;
  logic              neg_r, neg_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              bad_r, bad_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Shared arithmetic: one adder/subtractor and one signed compare
  time_t op_a, op_b, add_res;
  logic  op_sub;
  time_t cmp_a, cmp_b;
  logic  cmp_ge;

  logic             tok_bad;
  logic [IDX_W-1:0] tok_idx;

  assign add_res = op_a + (op_sub ? ~op_b : op_b) + {{(TIME_W-1){1'b0}}, op_sub};
  assign cmp_ge  = (cmp_a >= cmp_b);

  assign tok_bad = ({1'b0, tok_r} >= TOK_LIMIT);
  assign tok_idx = tok_r[IDX_W-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    tok_nxt       = tok_r;
    amt_nxt       = amt_r;
    idx_nxt       = idx_r;
    ph_nxt        = ph_r;
    now_nxt       = now_r;
    earliest_nxt  = earliest_r;
    last_sync_nxt = last_sync_r;
    deadline_nxt  = deadline_r;
    elapsed_nxt   = elapsed_r;
    neg_nxt       = neg_r;
    mask_nxt      = mask_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_a          = now_r;
    op_b          = amt_r;
    op_sub        = 1'b0;
    cmp_a         = now_r;
    cmp_b         = deadline_r[idx_r];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data.req_type;
          tok_nxt     = in_data.token;
          amt_nxt     = in_data.amount;
          idx_nxt     = '0;
          ph_nxt      = PH_FIRST;
          elapsed_nxt = '0;
          neg_nxt     = 1'b0;
          mask_nxt    = '0;
          bad_nxt     = 1'b0;
          state_nxt   = S_RUN;
        end
      end

      S_RUN: begin
        case (req_r)
          REQ_ADVANCE: begin
            now_nxt   = add_res;
            state_nxt = S_DONE;
          end

          REQ_RESYNC: begin
            if (tok_bad) begin
              bad_nxt = 1'b1;
            end else begin
              op_b                   = last_sync_r[tok_idx];
              op_sub                 = 1'b1;
              elapsed_nxt            = add_res;
              neg_nxt                = add_res[TIME_W-1];
              last_sync_nxt[tok_idx] = now_r;
            end
            state_nxt = S_DONE;
          end

          REQ_SCHEDULE: begin
            if (tok_bad) begin
              bad_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else if (ph_r == PH_FIRST) begin
              // write the new deadline, then scan for the minimum
              deadline_nxt[tok_idx] = add_res;
              ph_nxt                = PH_SECOND;
            end else begin
              cmp_a = deadline_r[idx_r];
              cmp_b = earliest_r;
              if (idx_r == '0 || !cmp_ge) begin
                earliest_nxt = deadline_r[idx_r];
              end
              if (idx_r == IDX_LAST) begin
                state_nxt = S_DONE;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end

          REQ_CHECK: begin
            if (cmp_ge) begin
              mask_nxt = mask_r | (MASK_W'(1) << idx_r);
            end
            if (idx_r == IDX_LAST) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end

          REQ_REBASE: begin
            op_sub = 1'b1;
            op_b   = now_r;
            case (ph_r)
              PH_FIRST: begin
                op_a                 = last_sync_r[idx_r];
                last_sync_nxt[idx_r] = add_res;
                ph_nxt               = PH_SECOND;
              end
              PH_SECOND: begin
                op_a                = deadline_r[idx_r];
                deadline_nxt[idx_r] = add_res;
                if (idx_r == IDX_LAST) begin
                  ph_nxt = PH_TAIL;
                end else begin
                  ph_nxt  = PH_FIRST;
                  idx_nxt = idx_r + 1'b1;
                end
              end
              default: begin
                // earliest shifts too, then the clock restarts at zero
                op_a         = earliest_r;
                earliest_nxt = add_res;
                now_nxt      = '0;
                state_nxt    = S_DONE;
              end
            endcase
          end

          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.elapsed           = elapsed_r;
          out_data_nxt.negative_sync     = neg_r;
          out_data_nxt.due_mask          = mask_r;
          out_data_nxt.earliest_deadline = earliest_r;
          out_data_nxt.current_time      = now_r;
          out_data_nxt.bad_token         = bad_r;
          out_valid_nxt                  = 1'b1;
          state_nxt                      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      now_r       <= '0;
      earliest_r  <= NEVER_TIME;
      for (int i = 0; i < NUM_TOKENS; i++) begin
        last_sync_r[i] <= '0;
        deadline_r[i]  <= NEVER_TIME;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      now_r       <= now_nxt;
      earliest_r  <= earliest_nxt;
      last_sync_r <= last_sync_nxt;
      deadline_r  <= deadline_nxt;
    end
  end

  // Payload and working registers, no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    tok_r      <= tok_nxt;
    amt_r      <= amt_nxt;
    idx_r      <= idx_nxt;
    ph_r       <= ph_nxt;
    elapsed_r  <= elapsed_nxt;
    neg_r      <= neg_nxt;
    mask_r     <= mask_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
